[rtl/cnmt_pkg.sv]
`timescale 1ns / 1ps

package cnmt_pkg;

  localparam logic [10:0] ID_NMT   = 11'h000;
  localparam logic [10:0] ID_SYNC  = 11'h080;
  localparam logic [10:0] ID_TXSDO = 11'h580;
  localparam logic [10:0] ID_RXSDO = 11'h600;
  localparam logic [10:0] ID_GUARD = 11'h700;

  localparam logic [6:0] ST_INIT    = 7'd0;
  localparam logic [6:0] ST_STOPPED = 7'd4;
  localparam logic [6:0] ST_OPER    = 7'd5;
  localparam logic [6:0] ST_PREOP   = 7'd127;

  localparam logic [7:0] NMT_START      = 8'h01;
  localparam logic [7:0] NMT_STOP       = 8'h02;
  localparam logic [7:0] NMT_PREOP      = 8'h80;
  localparam logic [7:0] NMT_RESET      = 8'h81;
  localparam logic [7:0] NMT_RESET_COMM = 8'h82;

  localparam logic [7:0] SDO_DL_1   = 8'h23;
  localparam logic [7:0] SDO_DL_2   = 8'h27;
  localparam logic [7:0] SDO_DL_3   = 8'h2B;
  localparam logic [7:0] SDO_DL_4   = 8'h2F;
  localparam logic [7:0] SDO_UL     = 8'h40;
  localparam logic [7:0] SDO_DL_ACK = 8'h60;
  localparam logic [7:0] SDO_UL_RSP = 8'h43;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROVIDER_MASK = 1'b1;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 160;

  typedef enum logic [2:0] {
    FK_IGNORE,
    FK_NMT,
    FK_GUARD,
    FK_SDO_DL,
    FK_SDO_UL,
    FK_SDO_BAD
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic        nmt_hit;
    logic        nmt_known;
    logic [6:0]  nmt_next;
    logic        in_range;
    logic        notify;
  } frame_dec_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIN
  } ctrl_state_t;

endpackage

[rtl/cnmt_dict.sv]
`timescale 1ns / 1ps

module cnmt_dict #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cnmt_decode.sv]
`timescale 1ns / 1ps

module cnmt_decode import cnmt_pkg::*; #(
  parameter int NUM_OBJECTS    = 16,
  parameter int NUM_SUBINDEXES = 8,
  parameter int ADDR_W         = 7
) (
  input  logic [10:0]       frame_id,
  input  logic [31:0]       payload_low,
  input  logic [6:0]        node_id,
  input  logic [15:0]       provider_mask,
  output frame_dec_t        dec,
  output logic [ADDR_W-1:0] addr
);

  localparam int OBJ_W = $clog2(NUM_OBJECTS);
  localparam int SUB_W = (NUM_SUBINDEXES > 1) ? $clog2(NUM_SUBINDEXES) : 1;

  logic [7:0]       cmd;
  logic [7:0]       target;
  logic [15:0]      obj;
  logic [7:0]       sub;
  logic [OBJ_W-1:0] obj_idx;
  logic [SUB_W-1:0] sub_idx;
  logic [31:0]      addr_full;

  assign cmd     = payload_low[7:0];
  assign target  = payload_low[15:8];
  assign obj     = payload_low[23:8];
  assign sub     = payload_low[31:24];
  assign obj_idx = obj[OBJ_W-1:0];
  assign sub_idx = sub[SUB_W-1:0];

  assign addr_full = 32'(obj_idx) * NUM_SUBINDEXES + 32'(sub_idx);
  assign addr      = addr_full[ADDR_W-1:0];

  always_comb begin
    dec           = '0;
    dec.kind      = FK_IGNORE;
    dec.nmt_next  = ST_INIT;
    dec.in_range  = (obj < 16'(NUM_OBJECTS)) && ({1'b0, sub} < 9'(NUM_SUBINDEXES));
    dec.notify    = dec.in_range && (obj < 16'd16) && provider_mask[obj[3:0]];
    dec.nmt_hit   = (target == 8'd0) || (target == {1'b0, node_id});

    unique case (cmd)
      NMT_START:      begin dec.nmt_known = 1'b1; dec.nmt_next = ST_OPER;    end
      NMT_STOP:       begin dec.nmt_known = 1'b1; dec.nmt_next = ST_STOPPED; end
      NMT_PREOP:      begin dec.nmt_known = 1'b1; dec.nmt_next = ST_PREOP;   end
      NMT_RESET:      begin dec.nmt_known = 1'b1; dec.nmt_next = ST_PREOP;   end
      NMT_RESET_COMM: begin dec.nmt_known = 1'b1; dec.nmt_next = ST_OPER;    end
      default:        dec.nmt_known = 1'b0;
    endcase

    if (frame_id == ID_SYNC) begin
      dec.kind = FK_IGNORE;
    end else if (frame_id == ID_NMT) begin
      dec.kind = FK_NMT;
    end else if (frame_id == ID_GUARD + {4'b0, node_id}) begin
      dec.kind = FK_GUARD;
    end else if (frame_id == ID_RXSDO + {4'b0, node_id}) begin
      unique case (cmd) inside
        SDO_DL_1, SDO_DL_2, SDO_DL_3, SDO_DL_4: dec.kind = FK_SDO_DL;
        SDO_UL:  dec.kind = FK_SDO_UL;
        default: dec.kind = FK_SDO_BAD;
      endcase
    end
  end

endmodule

[rtl/canopen_nmt_sdo_slave.sv]
`timescale 1ns / 1ps

// CANopen NMT slave with an expedited SDO server. Each received frame beat on s_axis gives
// exactly one result beat on m_axis. A frame is handled in order: accept, dictionary read, then
// commit of state, dictionary write-back and result; the commit waits while the previous
// result is still held in the output register, and a new frame is taken only after commit.
// The dictionary is a single-port-write, single-port-read RAM of NUM_OBJECTS*NUM_SUBINDEXES
// words; after reset it is cleared one word per cycle with s_axis_tready low.
// Configuration writes are taken at any time and should be issued only while idle.
module canopen_nmt_sdo_slave import cnmt_pkg::*; #(
  parameter int NUM_OBJECTS    = 16,
  parameter int NUM_SUBINDEXES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // frame_id, payload_low, payload_high, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // send, tx_id, tx_len, tx_low, tx_high, notify, notify_object, notify_subindex,
  // accepted, nmt_state, rx_count, tx_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int DEPTH  = NUM_OBJECTS * NUM_SUBINDEXES;
  localparam int ADDR_W = $clog2(DEPTH);

  ctrl_state_t state, state_next;

  logic [6:0]  node_id;
  logic [15:0] provider_mask;

  logic [10:0] frame_id;
  logic [31:0] payload_low;
  logic [31:0] payload_high;

  logic [6:0]  node_state, node_state_next;
  logic        guard_toggle, guard_toggle_next;
  logic [31:0] received_total;
  logic [31:0] sent_total;

  logic [ADDR_W-1:0] clr_cnt;
  logic              clr_done;

  frame_dec_t        dec;
  logic [ADDR_W-1:0] addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;

  logic        load;
  logic        send;
  logic [10:0] tx_id;
  logic [3:0]  tx_len;
  logic [31:0] tx_low;
  logic [31:0] tx_high;
  logic        notify;
  logic [3:0]  notify_object;
  logic [2:0]  notify_subindex;
  logic        accepted;
  logic        dl_write;

  logic [OUT_DATA_W-1:0] out_data;

  cnmt_decode #(
    .NUM_OBJECTS    (NUM_OBJECTS),
    .NUM_SUBINDEXES (NUM_SUBINDEXES),
    .ADDR_W         (ADDR_W)
  ) u_decode (
    .frame_id      (frame_id),
    .payload_low   (payload_low),
    .node_id       (node_id),
    .provider_mask (provider_mask),
    .dec           (dec),
    .addr          (addr)
  );

  cnmt_dict #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_EXEC),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= 7'd1;
      provider_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ID:       node_id       <= cfg_data[6:0];
        REG_PROVIDER_MASK: provider_mask <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign clr_done      = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign load          = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next        = state;
    node_state_next   = node_state;
    guard_toggle_next = guard_toggle;
    send              = 1'b0;
    tx_id             = '0;
    tx_len            = '0;
    tx_low            = '0;
    tx_high           = '0;
    notify            = 1'b0;
    notify_object     = '0;
    notify_subindex   = '0;
    accepted          = 1'b1;
    dl_write          = 1'b0;

    case (dec.kind)
      FK_NMT: begin
        if (dec.nmt_hit) begin
          accepted = dec.nmt_known;
          if (dec.nmt_known) begin
            node_state_next = dec.nmt_next;
          end
        end
      end
      FK_GUARD: begin
        guard_toggle_next = ~guard_toggle;
        send              = 1'b1;
        tx_id             = ID_GUARD + {4'b0, node_id};
        tx_len            = 4'd1;
        tx_low            = {24'b0, ~guard_toggle, node_state};
      end
      FK_SDO_DL: begin
        dl_write = dec.in_range;
        send     = 1'b1;
        tx_id    = ID_TXSDO + {4'b0, node_id};
        tx_len   = 4'd8;
        tx_low   = {payload_low[31:8], SDO_DL_ACK};
        if (dec.notify) begin
          notify          = 1'b1;
          notify_object   = payload_low[11:8];
          notify_subindex = payload_low[26:24];
        end
      end
      FK_SDO_UL: begin
        send    = 1'b1;
        tx_id   = ID_TXSDO + {4'b0, node_id};
        tx_len  = 4'd8;
        tx_low  = {payload_low[31:8], SDO_UL_RSP};
        tx_high = dec.in_range ? ram_rdata : 32'd0;
      end
      FK_SDO_BAD: accepted = 1'b0;
      default: ;
    endcase

    unique case (state)
      S_CLEAR: if (clr_done) state_next = S_IDLE;
      S_IDLE:  if (s_axis_tvalid) state_next = S_EXEC;
      S_EXEC:  state_next = S_FIN;
      S_FIN:   if (load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = load && dl_write;
      ram_waddr = addr;
      ram_wdata = payload_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      node_state     <= ST_INIT;
      guard_toggle   <= 1'b0;
      received_total <= '0;
      sent_total     <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (m_axis_tready && !load) begin
        m_axis_tvalid <= 1'b0;
      end
      if (load) begin
        node_state     <= node_state_next;
        guard_toggle   <= guard_toggle_next;
        received_total <= received_total + 32'd1;
        sent_total     <= sent_total + 32'(send);
        m_axis_tvalid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      frame_id     <= s_axis_tdata[10:0];
      payload_low  <= s_axis_tdata[42:11];
      payload_high <= s_axis_tdata[74:43];
    end
    if (load) begin
      out_data <= {sent_total + 32'(send), received_total + 32'd1, node_state_next, accepted,
                   notify_subindex, notify_object, notify, tx_high, tx_low, tx_len, tx_id,
                   send};
    end
  end

  assign m_axis_tdata = out_data;

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_EXEC)
    else $error("accepted beat did not start a dictionary read");

  a_rx_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(received_total))
    else $error("rx counter moved without a commit");

  a_tx_count: assert property (@(posedge clk) disable iff (rst)
    load |=> sent_total == $past(sent_total) + 32'($past(send)))
    else $error("tx counter out of step with replies");

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_FIN || state == S_CLEAR))
    else $error("dictionary written outside commit or clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule

[bench/canopen_nmt_sdo_slave_tb.sv]
`timescale 1ns / 1ps

module canopen_nmt_sdo_slave_tb;
  import cnmt_pkg::*;

  localparam int NUM_OBJ = 16;
  localparam int NUM_SUB = 8;

  // fields from the lowest bit up: frame_id, payload_low, payload_high, pad
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] payload_high;
    logic [31:0] payload_low;
    logic [10:0] frame_id;
  } can_frame_t;

  typedef struct packed {
    logic [31:0] tx_count;
    logic [31:0] rx_count;
    logic [6:0]  nmt_state;
    logic        accepted;
    logic [2:0]  notify_sub;
    logic [3:0]  notify_obj;
    logic        notify;
    logic [31:0] tx_high;
    logic [31:0] tx_low;
    logic [3:0]  tx_len;
    logic [10:0] tx_id;
    logic        send;
  } node_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  can_frame_t  pending_frames[$];
  node_reply_t expected_replies[$];
  int          mismatches = 0;

  // node image
  logic [31:0] od_words [0:NUM_OBJ*NUM_SUB-1];
  logic [6:0]  mdl_state = ST_INIT;
  logic        mdl_toggle = 1'b0;
  logic [31:0] mdl_rx = '0;
  logic [31:0] mdl_tx = '0;
  logic [6:0]  cfg_node = 7'd1;
  logic [15:0] cfg_mask = '0;

  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_cnt = '0;
  int          stall_mode = 0;

  canopen_nmt_sdo_slave #(
    .NUM_OBJECTS(NUM_OBJ),
    .NUM_SUBINDEXES(NUM_SUB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic node_reply_t service_frame(can_frame_t f);
    node_reply_t r;
    logic [7:0]  cmd;
    logic [15:0] obj;
    logic [7:0]  sub;
    logic        hit;
    r = '0;
    r.accepted = 1'b1;
    cmd = f.payload_low[7:0];
    obj = f.payload_low[23:8];
    sub = f.payload_low[31:24];
    hit = (obj < NUM_OBJ) && (sub < NUM_SUB);
    mdl_rx = mdl_rx + 1;
    if (f.frame_id == ID_SYNC) begin
      r.accepted = 1'b1;
    end else if (f.frame_id == ID_NMT) begin
      if (f.payload_low[15:8] == 8'd0 || f.payload_low[15:8] == {1'b0, cfg_node}) begin
        case (cmd)
          NMT_START, NMT_RESET_COMM: mdl_state = ST_OPER;
          NMT_STOP: mdl_state = ST_STOPPED;
          NMT_PREOP, NMT_RESET: mdl_state = ST_PREOP;
          default: r.accepted = 1'b0;
        endcase
      end
    end else if (f.frame_id == ID_GUARD + cfg_node) begin
      mdl_toggle = ~mdl_toggle;
      r.send = 1'b1;
      r.tx_id = ID_GUARD + cfg_node;
      r.tx_len = 4'd1;
      r.tx_low = {24'd0, mdl_toggle, mdl_state};
      mdl_tx = mdl_tx + 1;
    end else if (f.frame_id == ID_RXSDO + cfg_node) begin
      if (cmd == SDO_DL_1 || cmd == SDO_DL_2 || cmd == SDO_DL_3 || cmd == SDO_DL_4) begin
        if (hit) begin
          od_words[{obj[3:0], sub[2:0]}] = f.payload_high;
          if (cfg_mask[obj[3:0]]) begin
            r.notify = 1'b1;
            r.notify_obj = obj[3:0];
            r.notify_sub = sub[2:0];
          end
        end
        r.send = 1'b1;
        r.tx_id = ID_TXSDO + cfg_node;
        r.tx_len = 4'd8;
        r.tx_low = {sub, obj, SDO_DL_ACK};
        mdl_tx = mdl_tx + 1;
      end else if (cmd == SDO_UL) begin
        r.send = 1'b1;
        r.tx_id = ID_TXSDO + cfg_node;
        r.tx_len = 4'd8;
        r.tx_low = {sub, obj, SDO_UL_RSP};
        r.tx_high = hit ? od_words[{obj[3:0], sub[2:0]}] : 32'd0;
        mdl_tx = mdl_tx + 1;
      end else begin
        r.accepted = 1'b0;
      end
    end
    r.nmt_state = mdl_state;
    r.rx_count = mdl_rx;
    r.tx_count = mdl_tx;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0 || pending_frames.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_frames.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 16'd1;
      if (stall_cnt[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= stall_cnt[2:0] != 3'd0;
        default: m_axis_tready <= stall_cnt[1:0] == 2'd0;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    node_reply_t got;
    node_reply_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_replies.push_back(service_frame(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply beat expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("send", 32'(want.send), 32'(got.send));
          check_field("tx_id", 32'(want.tx_id), 32'(got.tx_id));
          check_field("tx_len", 32'(want.tx_len), 32'(got.tx_len));
          check_field("tx_low", want.tx_low, got.tx_low);
          check_field("tx_high", want.tx_high, got.tx_high);
          check_field("notify", 32'(want.notify), 32'(got.notify));
          check_field("notify_object", 32'(want.notify_obj), 32'(got.notify_obj));
          check_field("notify_subindex", 32'(want.notify_sub), 32'(got.notify_sub));
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("nmt_state", 32'(want.nmt_state), 32'(got.nmt_state));
          check_field("rx_count", want.rx_count, got.rx_count);
          check_field("tx_count", want.tx_count, got.tx_count);
        end
      end
    end
  end

  function automatic logic [31:0] sdo_lo(logic [7:0] cmd, logic [15:0] obj, logic [7:0] sub);
    return {sub, obj, cmd};
  endfunction

  function automatic logic [31:0] nmt_lo(logic [7:0] cmd, logic [7:0] target);
    logic [15:0] junk;
    junk = 16'($urandom);
    return {junk, target, cmd};
  endfunction

  task automatic queue_frame(logic [10:0] id, logic [31:0] lo, logic [31:0] hi);
    can_frame_t f;
    f = '0;
    f.frame_id = id;
    f.payload_low = lo;
    f.payload_high = hi;
    pending_frames.push_back(f);
  endtask

  task automatic queue_random_frame(output bit counted);
    int          r;
    int          k;
    logic [7:0]  cmd;
    logic [15:0] obj;
    logic [7:0]  sub;
    logic [6:0]  other;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 45) begin
      k = $urandom_range(0, 8);
      case (k)
        0: cmd = SDO_DL_1;
        1: cmd = SDO_DL_2;
        2: cmd = SDO_DL_3;
        3: cmd = SDO_DL_4;
        4, 5, 6: cmd = SDO_UL;
        default: cmd = 8'($urandom);
      endcase
      k = $urandom_range(0, 19);
      if (k < 8) begin
        obj = 16'($urandom_range(0, 3));
        sub = 8'($urandom_range(0, 3));
      end else if (k < 17) begin
        obj = 16'($urandom_range(0, NUM_OBJ - 1));
        sub = 8'($urandom_range(0, NUM_SUB - 1));
      end else if (k < 19) begin
        obj = 16'($urandom_range(NUM_OBJ - 1, NUM_OBJ + 1));
        sub = 8'($urandom_range(NUM_SUB - 1, NUM_SUB + 1));
      end else begin
        obj = 16'($urandom);
        sub = 8'($urandom);
      end
      queue_frame(ID_RXSDO + cfg_node, sdo_lo(cmd, obj, sub), $urandom);
    end else if (r < 60) begin
      queue_frame(ID_GUARD + cfg_node, $urandom, $urandom);
    end else if (r < 78) begin
      k = $urandom_range(0, 5);
      case (k)
        0: cmd = NMT_START;
        1: cmd = NMT_STOP;
        2: cmd = NMT_PREOP;
        3: cmd = NMT_RESET;
        4: cmd = NMT_RESET_COMM;
        default: cmd = 8'($urandom);
      endcase
      k = $urandom_range(0, 4);
      queue_frame(ID_NMT,
                  nmt_lo(cmd, (k < 2) ? 8'd0 : (k < 4) ? {1'b0, cfg_node} : 8'($urandom)),
                  $urandom);
    end else if (r < 83) begin
      queue_frame(ID_SYNC, $urandom, $urandom);
    end else if (r < 90) begin
      counted = 1'b0;
      other = cfg_node + 7'($urandom_range(1, 126));
      k = $urandom_range(0, 2);
      queue_frame((k == 0) ? ID_RXSDO + other : (k == 1) ? ID_GUARD + other : ID_TXSDO + cfg_node,
                  $urandom, $urandom);
    end else begin
      counted = 1'b0;
      queue_frame(11'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic run_random(int n);
    int useful;
    bit c;
    useful = 0;
    @(negedge clk);
    while (useful < n) begin
      queue_random_frame(c);
      useful += c;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_NODE_ID) cfg_node = val[6:0];
    else cfg_mask = val;
  endtask

  task automatic set_config(logic [15:0] node_val, logic [15:0] mask_val);
    wait_idle();
    write_reg(REG_NODE_ID, node_val);
    write_reg(REG_PROVIDER_MASK, mask_val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [6:0] n;
    for (int i = 0; i < NUM_OBJ * NUM_SUB; i++) od_words[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_frame(ID_GUARD + cfg_node, 32'd0, 32'd0);
    queue_frame(ID_GUARD + cfg_node, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_frame(ID_SYNC, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_frame(ID_NMT, nmt_lo(NMT_START, 8'd0), 32'd0);
    queue_frame(ID_NMT, nmt_lo(NMT_STOP, {1'b0, cfg_node}), 32'd0);
    queue_frame(ID_NMT, nmt_lo(NMT_PREOP, 8'd5), 32'd0);
    queue_frame(ID_NMT, nmt_lo(8'h55, 8'd0), 32'd0);
    queue_frame(ID_NMT, nmt_lo(NMT_RESET, 8'd0), 32'd0);
    queue_frame(ID_NMT, nmt_lo(NMT_RESET_COMM, {1'b0, cfg_node}), 32'd0);
    queue_frame(ID_NMT, nmt_lo(NMT_PREOP, 8'd0), 32'd0);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_DL_1, 16'd0, 8'd0), 32'hFFFFFFFF);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_DL_2, 16'd15, 8'd7), 32'h12345678);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_DL_3, 16'd16, 8'd0), 32'hA5A5A5A5);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_DL_4, 16'd3, 8'd8), 32'h5A5A5A5A);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_UL, 16'd0, 8'd0), 32'd0);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_UL, 16'd15, 8'd7), 32'd0);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_UL, 16'd16, 8'd0), 32'd0);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_UL, 16'hFFFF, 8'hFF), 32'hFFFFFFFF);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(8'h00, 16'd1, 8'd1), 32'd0);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(8'hFF, 16'd1, 8'd1), 32'd0);
    queue_frame(11'h7FF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_frame(ID_TXSDO + cfg_node, 32'hFFFFFFFF, 32'd0);
    queue_frame(ID_GUARD + cfg_node, 32'd0, 32'd0);

    set_config(16'h007F, 16'hFFFF);
    @(negedge clk);
    queue_frame(ID_RXSDO + cfg_node, sdo_lo(SDO_DL_4, 16'd15, 8'd7), 32'hCAFEF00D);
    queue_frame(ID_GUARD + cfg_node, 32'd0, 32'd0);
    run_random(315);

    set_config(16'hFF81, 16'h0000);
    run_random(315);

    n = 7'($urandom_range(2, 126));
    set_config({7'($urandom), 2'($urandom), n}, 16'($urandom));
    run_random(315);

    set_config(16'h0040, 16'h8001);
    run_random(315);

    n = 7'($urandom_range(1, 127));
    set_config({9'd0, n}, 16'($urandom));
    run_random(315);

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
